FILE: design/mtab_pkg.sv
// Shared types and constants for the address-learning table with aging.
// Holds field widths, operation and register codes, and the per-entry
// compare result type. Depends on nothing.
package mtab_pkg;

  localparam int OP_W      = 2;
  localparam int MAC_W     = 48;
  localparam int TIME_W    = 32;
  localparam int SLOT_W    = 5;
  localparam int COUNT_W   = 6;
  localparam int CFG_IDX_W = 1;

  localparam int IN_TDATA_W  = 88;
  localparam int OUT_TDATA_W = 24;

  // Operation codes of an input item.
  localparam logic [OP_W-1:0] OP_RECEIVE   = 2'd0;
  localparam logic [OP_W-1:0] OP_TICK      = 2'd1;
  localparam logic [OP_W-1:0] OP_BLACKLIST = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_DEVICE_TIMEOUT     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BLACKLIST_DURATION = 1'b1;

  localparam logic [TIME_W-1:0] DEVICE_TIMEOUT_RST     = 32'd15000;
  localparam logic [TIME_W-1:0] BLACKLIST_DURATION_RST = 32'd60000;

  localparam logic [MAC_W-1:0] ALL_ONES_ADDR = 48'hFFFF_FFFF_FFFF;

  // Compare results for one tracked entry and one block entry.
  typedef struct packed {
    logic t_match;    // tracked address equals the item address
    logic t_aged;     // device silent longer than the timeout
    logic b_match;    // block address equals the item address
    logic b_live;     // block entry still in force at the item time
    logic b_expired;  // block entry past its expiry
  } eval_t;

endpackage

FILE: design/mac_table_aging_blacklist_top.sv
// Top level of the address-learning table with aging and a blocking list.
// Depends on mtab_pkg and instantiates mtab_entry_eval.
//
// The block keeps a tracked-device table and a block table, each scanned one
// entry per cycle through a single read port per table, with one shared
// compare unit looking at the entry of both tables at the same index. A
// receive, tick or blacklist item passes through its accept cycle, the scan,
// a drain step for the registered memory read, and a commit step that
// updates the tables and loads the result register, and only then is the
// next item accepted. A broadcast receive or an unknown operation skips the
// scan and goes from the accept cycle straight to commit. The commit waits
// while a previous result has not been taken.
// Valid bits sit in flip-flops and clear at reset; the address and time stores
// need no clearing. Configuration writes are taken at any time but are meant
// for idle.
module mac_table_aging_blacklist_top #(
  parameter int TRACK_ENTRIES = 32,
  parameter int BLOCK_ENTRIES = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input item: operation [1:0], mac_address [49:2], now_ms [81:50], zero pad.
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [mtab_pkg::IN_TDATA_W-1:0]     in_tdata,
  // Result item: accepted [0], track_slot [5:1], new_device [6],
  // track_full [7], blacklist_full [8], removed_count [14:9],
  // active_count [20:15], zero pad.
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [mtab_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // Configuration write port.
  input  logic                                cfg_wr_en,
  input  logic [mtab_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mtab_pkg::TIME_W-1:0]         cfg_wdata
);
  import mtab_pkg::*;

  localparam int SCAN_N = (TRACK_ENTRIES > BLOCK_ENTRIES) ? TRACK_ENTRIES : BLOCK_ENTRIES;
  localparam int IDX_W  = (SCAN_N > 1) ? $clog2(SCAN_N) : 1;
  localparam int TW     = (TRACK_ENTRIES > 1) ? $clog2(TRACK_ENTRIES) : 1;
  localparam int BW     = (BLOCK_ENTRIES > 1) ? $clog2(BLOCK_ENTRIES) : 1;
  localparam int CNT_W  = $clog2(TRACK_ENTRIES + 1);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SCAN_N - 1);
  localparam logic [IDX_W:0]   T_LIM    = (IDX_W + 1)'(TRACK_ENTRIES);
  localparam logic [IDX_W:0]   B_LIM    = (IDX_W + 1)'(BLOCK_ENTRIES);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DRAIN, ST_COMMIT} state_t;

  // Control state.
  state_t                   state_r, state_nxt;
  logic [IDX_W-1:0]         idx_r, idx_nxt;
  logic [IDX_W-1:0]         idx_d_r, idx_d_nxt;
  logic                     rd_vld_r, rd_vld_nxt;
  logic [TIME_W-1:0]        timeout_r, timeout_nxt;
  logic [TIME_W-1:0]        duration_r, duration_nxt;
  logic [TRACK_ENTRIES-1:0] track_valid_r, track_valid_nxt;
  logic [BLOCK_ENTRIES-1:0] block_valid_r, block_valid_nxt;
  logic [CNT_W-1:0]         active_r, active_nxt;
  logic                     out_tvalid_r, out_tvalid_nxt;

  // Item and scan payload.
  logic [OP_W-1:0]          op_r, op_nxt;
  logic [MAC_W-1:0]         addr_r, addr_nxt;
  logic [TIME_W-1:0]        now_r, now_nxt;
  logic [CNT_W-1:0]         removed_r, removed_nxt;
  logic                     t_hit_r, t_hit_nxt;
  logic [TW-1:0]            t_idx_r, t_idx_nxt;
  logic                     t_free_r, t_free_nxt;
  logic [TW-1:0]            t_free_idx_r, t_free_idx_nxt;
  logic                     b_hit_r, b_hit_nxt;
  logic [BW-1:0]            b_idx_r, b_idx_nxt;
  logic                     b_live_r, b_live_nxt;
  logic                     b_free_r, b_free_nxt;
  logic [BW-1:0]            b_free_idx_r, b_free_idx_nxt;

  // Result register fields.
  logic                     out_acc_r, out_acc_nxt;
  logic [SLOT_W-1:0]        out_slot_r, out_slot_nxt;
  logic                     out_new_r, out_new_nxt;
  logic                     out_tfull_r, out_tfull_nxt;
  logic                     out_bfull_r, out_bfull_nxt;
  logic [COUNT_W-1:0]       out_removed_r, out_removed_nxt;
  logic [COUNT_W-1:0]       out_active_r, out_active_nxt;

  // Memories and their ports.
  logic [MAC_W-1:0]  track_mac_mem [TRACK_ENTRIES];
  logic [TIME_W-1:0] track_ls_mem  [TRACK_ENTRIES];
  logic [MAC_W-1:0]  block_mac_mem [BLOCK_ENTRIES];
  logic [TIME_W-1:0] block_exp_mem [BLOCK_ENTRIES];
  logic [MAC_W-1:0]  tmac_q, bmac_q;
  logic [TIME_W-1:0] tls_q, bexp_q;
  logic              tmac_we, tls_we, bmem_we;
  logic [TW-1:0]     t_wr_idx;
  logic [BW-1:0]     b_wr_idx;
  logic [TIME_W-1:0] bexp_wdata;

  eval_t ev;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {3'b000, out_active_r, out_removed_r, out_bfull_r, out_tfull_r,
                       out_new_r, out_slot_r, out_acc_r};

  // Shared compare unit on the entries read this scan step.
  mtab_entry_eval u_eval (
    .addr            (addr_r),
    .now             (now_r),
    .timeout         (timeout_r),
    .track_mac       (tmac_q),
    .track_last_seen (tls_q),
    .block_mac       (bmac_q),
    .block_expiry    (bexp_q),
    .result          (ev)
  );

  // Table memories: one write at commit, one registered read per scan step.
  always_ff @(posedge clk) begin
    if (tmac_we) begin
      track_mac_mem[t_wr_idx] <= addr_r;
    end
    if (tls_we) begin
      track_ls_mem[t_wr_idx] <= now_r;
    end
    if (bmem_we) begin
      block_mac_mem[b_wr_idx] <= addr_r;
      block_exp_mem[b_wr_idx] <= bexp_wdata;
    end
    tmac_q <= track_mac_mem[idx_r[TW-1:0]];
    tls_q  <= track_ls_mem[idx_r[TW-1:0]];
    bmac_q <= block_mac_mem[idx_r[BW-1:0]];
    bexp_q <= block_exp_mem[idx_r[BW-1:0]];
  end

  // Sequencer, scan evaluation and commit.
  always_comb begin
    logic [TW-1:0]    jt;
    logic [BW-1:0]    jb;
    logic             t_in, b_in, tv, bv;
    logic [CNT_W-1:0] rem_v;

    state_nxt       = state_r;
    idx_nxt         = idx_r;
    idx_d_nxt       = idx_d_r;
    rd_vld_nxt      = 1'b0;
    timeout_nxt     = timeout_r;
    duration_nxt    = duration_r;
    track_valid_nxt = track_valid_r;
    block_valid_nxt = block_valid_r;
    active_nxt      = active_r;
    out_tvalid_nxt  = out_tvalid_r;
    op_nxt          = op_r;
    addr_nxt        = addr_r;
    now_nxt         = now_r;
    removed_nxt     = removed_r;
    t_hit_nxt       = t_hit_r;
    t_idx_nxt       = t_idx_r;
    t_free_nxt      = t_free_r;
    t_free_idx_nxt  = t_free_idx_r;
    b_hit_nxt       = b_hit_r;
    b_idx_nxt       = b_idx_r;
    b_live_nxt      = b_live_r;
    b_free_nxt      = b_free_r;
    b_free_idx_nxt  = b_free_idx_r;
    out_acc_nxt     = out_acc_r;
    out_slot_nxt    = out_slot_r;
    out_new_nxt     = out_new_r;
    out_tfull_nxt   = out_tfull_r;
    out_bfull_nxt   = out_bfull_r;
    out_removed_nxt = out_removed_r;
    out_active_nxt  = out_active_r;
    tmac_we         = 1'b0;
    tls_we          = 1'b0;
    bmem_we         = 1'b0;
    t_wr_idx        = t_idx_r;
    b_wr_idx        = b_idx_r;
    bexp_wdata      = now_r + duration_r;
    rem_v           = '0;

    jt   = idx_d_r[TW-1:0];
    jb   = idx_d_r[BW-1:0];
    t_in = ({1'b0, idx_d_r} < T_LIM);
    b_in = ({1'b0, idx_d_r} < B_LIM);
    tv   = t_in && track_valid_r[jt];
    bv   = b_in && block_valid_r[jb];

    // Configuration writes.
    if (cfg_wr_en) begin
      case (cfg_index)
        REG_DEVICE_TIMEOUT:     timeout_nxt  = cfg_wdata;
        REG_BLACKLIST_DURATION: duration_nxt = cfg_wdata;
        default: ;
      endcase
    end

    // A taken result frees the output register.
    if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          op_nxt      = in_tdata[OP_W-1:0];
          addr_nxt    = in_tdata[OP_W+MAC_W-1:OP_W];
          now_nxt     = in_tdata[OP_W+MAC_W+TIME_W-1:OP_W+MAC_W];
          idx_nxt     = '0;
          removed_nxt = '0;
          t_hit_nxt   = 1'b0;
          t_free_nxt  = 1'b0;
          b_hit_nxt   = 1'b0;
          b_free_nxt  = 1'b0;
          if ((in_tdata[OP_W-1:0] == OP_RECEIVE &&
               in_tdata[OP_W+MAC_W-1:OP_W] != ALL_ONES_ADDR) ||
              in_tdata[OP_W-1:0] == OP_TICK ||
              in_tdata[OP_W-1:0] == OP_BLACKLIST) begin
            state_nxt = ST_SCAN;
          end else begin
            state_nxt = ST_COMMIT;
          end
        end
      end
      ST_SCAN: begin
        rd_vld_nxt = 1'b1;
        idx_d_nxt  = idx_r;
        if (idx_r == LAST_IDX) begin
          state_nxt = ST_DRAIN;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (!out_tvalid_r || out_tready) begin
          out_acc_nxt   = 1'b0;
          out_slot_nxt  = '0;
          out_new_nxt   = 1'b0;
          out_tfull_nxt = 1'b0;
          out_bfull_nxt = 1'b0;
          case (op_r)
            OP_RECEIVE: begin
              if (addr_r == ALL_ONES_ADDR) begin
                out_acc_nxt = 1'b1;
              end else if (b_hit_r && b_live_r) begin
                out_acc_nxt = 1'b0;
              end else begin
                out_acc_nxt = 1'b1;
                // An expired block entry for this address is dropped.
                if (b_hit_r) begin
                  block_valid_nxt[b_idx_r] = 1'b0;
                end
                if (t_hit_r) begin
                  tls_we       = 1'b1;
                  t_wr_idx     = t_idx_r;
                  out_slot_nxt = SLOT_W'(t_idx_r);
                end else if (t_free_r) begin
                  track_valid_nxt[t_free_idx_r] = 1'b1;
                  tmac_we      = 1'b1;
                  tls_we       = 1'b1;
                  t_wr_idx     = t_free_idx_r;
                  out_slot_nxt = SLOT_W'(t_free_idx_r);
                  out_new_nxt  = 1'b1;
                  active_nxt   = active_r + CNT_W'(1);
                end else begin
                  out_tfull_nxt = 1'b1;
                end
              end
            end
            OP_TICK: begin
              rem_v = removed_r;
            end
            OP_BLACKLIST: begin
              if (b_hit_r || b_free_r) begin
                b_wr_idx = b_hit_r ? b_idx_r : b_free_idx_r;
                bmem_we  = 1'b1;
                block_valid_nxt[b_wr_idx] = 1'b1;
                // Evict the address from the tracked table.
                if (t_hit_r) begin
                  track_valid_nxt[t_idx_r] = 1'b0;
                  active_nxt = active_r - CNT_W'(1);
                  rem_v      = CNT_W'(1);
                end
              end else begin
                out_bfull_nxt = 1'b1;
              end
            end
            default: ;
          endcase
          out_removed_nxt = COUNT_W'(rem_v);
          out_active_nxt  = COUNT_W'(active_nxt);
          out_tvalid_nxt  = 1'b1;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Scan step: judge the entries whose read data arrived this cycle.
    if (rd_vld_r) begin
      case (op_r)
        OP_TICK: begin
          if (tv && ev.t_aged) begin
            track_valid_nxt[jt] = 1'b0;
            removed_nxt = removed_r + CNT_W'(1);
            active_nxt  = active_r - CNT_W'(1);
          end
          if (bv && ev.b_expired) begin
            block_valid_nxt[jb] = 1'b0;
          end
        end
        default: begin
          // Lowest matching and lowest free slot of each table.
          if (!t_hit_r && tv && ev.t_match) begin
            t_hit_nxt = 1'b1;
            t_idx_nxt = jt;
          end
          if (!t_free_r && t_in && !tv) begin
            t_free_nxt     = 1'b1;
            t_free_idx_nxt = jt;
          end
          if (!b_hit_r && bv && ev.b_match) begin
            b_hit_nxt  = 1'b1;
            b_idx_nxt  = jb;
            b_live_nxt = ev.b_live;
          end
          if (!b_free_r && b_in && !bv) begin
            b_free_nxt     = 1'b1;
            b_free_idx_nxt = jb;
          end
        end
      endcase
    end
  end

  // Control registers and state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      idx_r         <= '0;
      idx_d_r       <= '0;
      rd_vld_r      <= 1'b0;
      timeout_r     <= DEVICE_TIMEOUT_RST;
      duration_r    <= BLACKLIST_DURATION_RST;
      track_valid_r <= '0;
      block_valid_r <= '0;
      active_r      <= '0;
      out_tvalid_r  <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      idx_r         <= idx_nxt;
      idx_d_r       <= idx_d_nxt;
      rd_vld_r      <= rd_vld_nxt;
      timeout_r     <= timeout_nxt;
      duration_r    <= duration_nxt;
      track_valid_r <= track_valid_nxt;
      block_valid_r <= block_valid_nxt;
      active_r      <= active_nxt;
      out_tvalid_r  <= out_tvalid_nxt;
    end
  end

  // Item, scan and result payload.
  always_ff @(posedge clk) begin
    op_r          <= op_nxt;
    addr_r        <= addr_nxt;
    now_r         <= now_nxt;
    removed_r     <= removed_nxt;
    t_hit_r       <= t_hit_nxt;
    t_idx_r       <= t_idx_nxt;
    t_free_r      <= t_free_nxt;
    t_free_idx_r  <= t_free_idx_nxt;
    b_hit_r       <= b_hit_nxt;
    b_idx_r       <= b_idx_nxt;
    b_live_r      <= b_live_nxt;
    b_free_r      <= b_free_nxt;
    b_free_idx_r  <= b_free_idx_nxt;
    out_acc_r     <= out_acc_nxt;
    out_slot_r    <= out_slot_nxt;
    out_new_r     <= out_new_nxt;
    out_tfull_r   <= out_tfull_nxt;
    out_bfull_r   <= out_bfull_nxt;
    out_removed_r <= out_removed_nxt;
    out_active_r  <= out_active_nxt;
  end

  // The running device count always agrees with the valid bits.
  a_active_count: assert property (@(posedge clk) disable iff (!rst_n)
    active_r == CNT_W'($countones(track_valid_r)))
    else $error("active count out of step with valid bits");

  // No scan read is in flight while a new item can be taken.
  a_idle_no_read: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !rd_vld_r)
    else $error("scan read pending while idle");

  // A commit holds while the previous result is still waiting.
  a_commit_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_COMMIT && out_tvalid_r && !out_tready) |=> state_r == ST_COMMIT)
    else $error("commit overwrote a waiting result");

  // A newly learned device can never also report a full table.
  a_new_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r |-> !(out_new_r && out_tfull_r))
    else $error("new device reported together with full table");

endmodule

FILE: design/mtab_entry_eval.sv
// Per-entry compare unit shared by every step of the table scan.
// Depends on mtab_pkg for widths and the eval_t result type.
module mtab_entry_eval (
  input  logic [mtab_pkg::MAC_W-1:0]  addr,
  input  logic [mtab_pkg::TIME_W-1:0] now,
  input  logic [mtab_pkg::TIME_W-1:0] timeout,
  input  logic [mtab_pkg::MAC_W-1:0]  track_mac,
  input  logic [mtab_pkg::TIME_W-1:0] track_last_seen,
  input  logic [mtab_pkg::MAC_W-1:0]  block_mac,
  input  logic [mtab_pkg::TIME_W-1:0] block_expiry,
  output mtab_pkg::eval_t             result
);
  import mtab_pkg::*;

  logic [TIME_W-1:0] silence;

  // Elapsed time wraps modulo 2^32, so plain subtraction is safe.
  assign silence = now - track_last_seen;

  always_comb begin
    result.t_match   = (track_mac == addr);
    result.t_aged    = (silence > timeout);
    result.b_match   = (block_mac == addr);
    result.b_expired = (now > block_expiry);
    result.b_live    = !(now > block_expiry);
  end

endmodule

FILE: bench/tb_mac_table_aging_blacklist_top.sv
// Self-checking testbench for mac_table_aging_blacklist_top.
// Depends on mtab_pkg and the RTL. A shadow copy of both address tables
// predicts every result item, and a scoreboard class checks each one.
`timescale 1ns / 1ps

module tb_mac_table_aging_blacklist_top;
  import mtab_pkg::*;

  localparam int TRACK_N       = 32;
  localparam int BLOCK_N       = 32;
  localparam int POOL_N        = 40;
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT   = 1000000;

  // The operation code the block must treat as a no-op.
  localparam logic [OP_W-1:0] OP_UNKNOWN = 2'd3;

  // Result item layout, lowest bit last.
  typedef struct packed {
    logic [2:0]         pad;
    logic [COUNT_W-1:0] active_count;
    logic [COUNT_W-1:0] removed_count;
    logic               blacklist_full;
    logic               track_full;
    logic               new_device;
    logic [SLOT_W-1:0]  track_slot;
    logic               accepted;
  } table_result_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_wr_en;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [TIME_W-1:0]      cfg_wdata;

  // Shadow of both tables plus the queue of results still owed by the block.
  class table_shadow;
    logic [TIME_W-1:0] timeout_ms;
    logic [TIME_W-1:0] duration_ms;
    bit                track_used[TRACK_N];
    logic [MAC_W-1:0]  track_addr[TRACK_N];
    logic [TIME_W-1:0] track_seen[TRACK_N];
    bit                block_used[BLOCK_N];
    logic [MAC_W-1:0]  block_addr[BLOCK_N];
    logic [TIME_W-1:0] block_until[BLOCK_N];
    table_result_t     owed_results[$];
    int                mismatches;
    int                results_seen;

    function new();
      timeout_ms   = DEVICE_TIMEOUT_RST;
      duration_ms  = BLACKLIST_DURATION_RST;
      mismatches   = 0;
      results_seen = 0;
      foreach (track_used[i]) track_used[i] = 1'b0;
      foreach (block_used[i]) block_used[i] = 1'b0;
    endfunction

    function void set_timing(logic [TIME_W-1:0] timeout, logic [TIME_W-1:0] duration);
      timeout_ms  = timeout;
      duration_ms = duration;
    endfunction

    function int pending();
      return owed_results.size();
    endfunction

    function int find_track(logic [MAC_W-1:0] mac);
      foreach (track_used[i])
        if (track_used[i] && track_addr[i] == mac) return i;
      return -1;
    endfunction

    function int find_block(logic [MAC_W-1:0] mac);
      foreach (block_used[i])
        if (block_used[i] && block_addr[i] == mac) return i;
      return -1;
    endfunction

    // Apply one accepted item to the shadow tables and queue its result.
    function void note_item(logic [OP_W-1:0] op, logic [MAC_W-1:0] mac,
                            logic [TIME_W-1:0] now);
      table_result_t     r;
      int                hit;
      int                removed;
      int                active;
      logic [TIME_W-1:0] expiry_ms;
      r       = '0;
      removed = 0;
      active  = 0;
      case (op)
        OP_RECEIVE: begin
          r.accepted = 1'b1;
          if (mac != ALL_ONES_ADDR) begin
            // A live block entry drops the frame; a stale one is cleared.
            hit = find_block(mac);
            if (hit >= 0) begin
              if (now <= block_until[hit]) r.accepted = 1'b0;
              else block_used[hit] = 1'b0;
            end
            if (r.accepted) begin
              hit = find_track(mac);
              if (hit >= 0) begin
                track_seen[hit] = now;
                r.track_slot    = hit[SLOT_W-1:0];
              end else begin
                for (int i = 0; i < TRACK_N && hit < 0; i++)
                  if (!track_used[i]) hit = i;
                if (hit < 0) begin
                  r.track_full = 1'b1;
                end else begin
                  track_used[hit] = 1'b1;
                  track_addr[hit] = mac;
                  track_seen[hit] = now;
                  r.track_slot    = hit[SLOT_W-1:0];
                  r.new_device    = 1'b1;
                end
              end
            end
          end
        end
        OP_TICK: begin
          // Silence is measured modulo 2^32; block expiry is a plain compare.
          foreach (track_used[i])
            if (track_used[i] && TIME_W'(now - track_seen[i]) > timeout_ms) begin
              track_used[i] = 1'b0;
              removed++;
            end
          foreach (block_used[i])
            if (block_used[i] && now > block_until[i]) block_used[i] = 1'b0;
        end
        OP_BLACKLIST: begin
          expiry_ms = now + duration_ms;
          hit       = find_block(mac);
          for (int i = 0; i < BLOCK_N && hit < 0; i++)
            if (!block_used[i]) hit = i;
          if (hit < 0) begin
            r.blacklist_full = 1'b1;
          end else begin
            block_used[hit]  = 1'b1;
            block_addr[hit]  = mac;
            block_until[hit] = expiry_ms;
            hit = find_track(mac);
            if (hit >= 0) begin
              track_used[hit] = 1'b0;
              removed = 1;
            end
          end
        end
        default: begin
        end
      endcase
      foreach (track_used[i]) if (track_used[i]) active++;
      r.removed_count = removed[COUNT_W-1:0];
      r.active_count  = active[COUNT_W-1:0];
      owed_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d: %s expected %0h, got %0h", results_seen, name, want, got);
      end
    endfunction

    // Compare one accepted result item against the oldest owed result.
    function void check_result(logic [OUT_TDATA_W-1:0] data);
      table_result_t got;
      table_result_t want;
      got = data;
      if (owed_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d: unexpected item %0h", results_seen, data);
      end else begin
        want = owed_results.pop_front();
        compare_field("accepted", 8'(want.accepted), 8'(got.accepted));
        compare_field("track_slot", 8'(want.track_slot), 8'(got.track_slot));
        compare_field("new_device", 8'(want.new_device), 8'(got.new_device));
        compare_field("track_full", 8'(want.track_full), 8'(got.track_full));
        compare_field("blacklist_full", 8'(want.blacklist_full), 8'(got.blacklist_full));
        compare_field("removed_count", 8'(want.removed_count), 8'(got.removed_count));
        compare_field("active_count", 8'(want.active_count), 8'(got.active_count));
        compare_field("padding", 8'(want.pad), 8'(got.pad));
      end
      results_seen++;
    endfunction
  endclass

  table_shadow       shadow;
  logic [MAC_W-1:0]  mac_pool[POOL_N];
  logic [TIME_W-1:0] wall_ms;
  bit                in_busy;
  bit                out_busy;
  int                cycle_count = 0;

  mac_table_aging_blacklist_top #(
    .TRACK_ENTRIES(TRACK_N),
    .BLOCK_ENTRIES(BLOCK_N)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Run guard against a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Random wait before an item, zero while a side is in a burst stretch.
  function automatic int draw_gap(ref bit busy);
    if ($urandom_range(0, 39) == 0) busy = !busy;
    return busy ? $urandom_range(0, 18) : 0;
  endfunction

  // Offer one item; called and returns on a falling edge.
  task automatic send_item(input logic [OP_W-1:0] op, input logic [MAC_W-1:0] mac,
                           input logic [TIME_W-1:0] now);
    int gap;
    gap = draw_gap(in_busy);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata  <= {6'b0, now, mac, op};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    shadow.note_item(op, mac, now);
    @(negedge clk);
  endtask

  // Drop valid, wait for every owed result, then let the block go quiet.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (shadow.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Write both timing registers while the block is idle.
  task automatic retime(input logic [TIME_W-1:0] timeout, input logic [TIME_W-1:0] duration);
    settle();
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_DEVICE_TIMEOUT;
    cfg_wdata <= timeout;
    @(negedge clk);
    cfg_index <= REG_BLACKLIST_DURATION;
    cfg_wdata <= duration;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    shadow.set_timing(timeout, duration);
  endtask

  // Random traffic over a pool of addresses with a mostly advancing clock.
  task automatic run_traffic(input int items, input int pool_n, input int step_max,
                             input int recv_w, input int tick_w, input int bl_w);
    int               roll;
    logic [OP_W-1:0]  op;
    logic [MAC_W-1:0] mac;
    repeat (items) begin
      if ($urandom_range(0, 59) == 0) wall_ms = $urandom;
      else wall_ms += $urandom_range(0, step_max);
      roll = $urandom_range(0, 99);
      if (roll < recv_w) op = OP_RECEIVE;
      else if (roll < recv_w + tick_w) op = OP_TICK;
      else if (roll < recv_w + tick_w + bl_w) op = OP_BLACKLIST;
      else op = OP_UNKNOWN;
      roll = $urandom_range(0, 99);
      if (roll < 4) mac = MAC_W'({$urandom, $urandom});
      else if (roll < 7) mac = ALL_ONES_ADDR;
      else mac = mac_pool[$urandom_range(0, pool_n - 1)];
      send_item(op, mac, wall_ms);
    end
  endtask

  // Result side: random stall before each item, then check it.
  initial begin
    int stall;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      stall = draw_gap(out_busy);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      shadow.check_result(out_tdata);
      @(negedge clk);
    end
  end

  // Main sequence.
  initial begin
    logic [MAC_W-1:0] dev_a;
    logic [MAC_W-1:0] dev_b;
    shadow    = new();
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_wr_en = 1'b0;
    cfg_index = REG_DEVICE_TIMEOUT;
    cfg_wdata = '0;
    in_busy   = 1'b0;
    out_busy  = 1'b1;
    dev_a     = 48'h0123_4567_89AB;
    dev_b     = 48'h8000_0000_0001;
    foreach (mac_pool[i]) begin
      mac_pool[i] = MAC_W'({$urandom, $urandom});
      if (mac_pool[i] == ALL_ONES_ADDR) mac_pool[i] = 48'h0;
    end
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part under the reset timing values.
    send_item(OP_RECEIVE, dev_a, 32'd1000);          // learn into slot 0
    send_item(OP_RECEIVE, dev_a, 32'd1500);          // refresh slot 0
    send_item(OP_RECEIVE, 48'h0, 32'd1600);          // all-zero address learned
    send_item(OP_RECEIVE, ALL_ONES_ADDR, 32'd1700);  // broadcast bypass
    send_item(OP_UNKNOWN, ALL_ONES_ADDR, 32'hFFFF_FFFF);
    send_item(OP_BLACKLIST, dev_a, 32'd2000);        // block and evict
    send_item(OP_RECEIVE, dev_a, 32'd3000);          // dropped
    send_item(OP_RECEIVE, dev_a, 32'd62000);         // dropped at exact expiry
    send_item(OP_RECEIVE, dev_a, 32'd62001);         // stale entry cleared
    send_item(OP_BLACKLIST, dev_b, 32'hFFFF_FFF0);   // expiry wraps past zero
    send_item(OP_RECEIVE, dev_b, 32'hFFFF_FFF0);     // wrapped expiry already past
    send_item(OP_BLACKLIST, dev_b, 32'd100);         // block again and evict
    send_item(OP_TICK, dev_a, 32'd17000);            // wrap-safe aging of both
    send_item(OP_TICK, 48'h0, 32'd60101);            // block entry expires
    send_item(OP_RECEIVE, dev_b, 32'd60102);
    send_item(OP_RECEIVE, 48'h0, 32'd60103);
    send_item(OP_TICK, dev_b, 32'd75103);            // one at the limit, one past it
    send_item(OP_BLACKLIST, ALL_ONES_ADDR, 32'd0);
    send_item(OP_RECEIVE, ALL_ONES_ADDR, 32'd1);     // broadcast ignores the block
    send_item(OP_BLACKLIST, 48'h0, 32'hFFFF_FFFF);
    send_item(OP_RECEIVE, 48'h0, 32'd0);
    send_item(OP_UNKNOWN, MAC_W'({$urandom, $urandom}), $urandom);
    wall_ms = 32'd100000;

    // Nothing ages: both tables fill up.
    retime(32'hFFFF_FFFF, 32'd1000000);
    run_traffic(400, POOL_N, 50, 70, 10, 18);

    // Zero timing: equal times and instant aging.
    retime(32'd0, 32'd0);
    run_traffic(300, 8, 3, 50, 30, 18);

    // Short timing across the 32-bit time wrap.
    retime(32'd300, 32'd500);
    wall_ms = 32'hFFFF_F000;
    run_traffic(400, 24, 60, 60, 20, 18);

    // Half-range timeout, largest duration, coarse time steps.
    retime(32'h8000_0000, 32'hFFFF_FFFF);
    run_traffic(300, 16, 32'h4000_0000, 60, 20, 18);

    // Random moderate timing.
    retime($urandom_range(0, 5000), $urandom_range(0, 5000));
    run_traffic(600, 36, 200, 60, 20, 18);

    settle();
    if (shadow.mismatches == 0 && shadow.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
